### rtl/dirl_pkg.sv
// Package for the directory entry lookup block: entry kinds, byte offsets within
// a 32-byte directory entry and the register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dirl_pkg;

  localparam int unsigned NameBytes = 11;

  // Byte offsets within one directory entry.
  localparam logic [4:0] OFF_LEAD       = 5'd0;
  localparam logic [4:0] OFF_ATTR       = 5'd11;
  localparam logic [4:0] OFF_CLUS_HI_LO = 5'd20;
  localparam logic [4:0] OFF_CLUS_HI_HI = 5'd21;
  localparam logic [4:0] OFF_CLUS_LO_LO = 5'd26;
  localparam logic [4:0] OFF_CLUS_LO_HI = 5'd27;
  localparam logic [4:0] OFF_SIZE_0     = 5'd28;
  localparam logic [4:0] OFF_SIZE_1     = 5'd29;
  localparam logic [4:0] OFF_SIZE_2     = 5'd30;
  localparam logic [4:0] OFF_LAST       = 5'd31;

  localparam logic [7:0] LEAD_END_OF_LIST = 8'h00;
  localparam logic [7:0] LEAD_DELETED     = 8'hE5;
  localparam logic [3:0] ATTR_LFN_NIBBLE  = 4'hF;
  localparam int unsigned AttrDirBit      = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_NAME_BASE  = 2'd0;
  localparam logic [1:0] REG_NAME_EXT   = 2'd1;
  localparam logic [1:0] REG_FAT32_MODE = 2'd2;

  typedef enum logic [2:0] {
    KIND_LONG_NAME   = 3'd0,
    KIND_DELETED     = 3'd1,
    KIND_END_OF_LIST = 3'd2,
    KIND_NO_MATCH    = 3'd3,
    KIND_FILE_MATCH  = 3'd4,
    KIND_DIR_MATCH   = 3'd5
  } entry_kind_e;

  typedef struct packed {
    entry_kind_e kind;
    logic [3:0]  slot;
    logic [7:0]  attributes;
    logic [31:0] start_cluster;
    logic [31:0] entry_size;
  } dirl_entry_t;

endpackage

`default_nettype wire

### rtl/dirl_collect.sv
// Byte collector and classifier for 32-byte directory entries.
// Depends on dirl_pkg for offsets, kinds and the entry result struct.
`timescale 1ns / 1ps
`default_nettype none

module dirl_collect #(
  parameter int unsigned ENTRIES_PER_SECTOR = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               byte_take_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic [63:0]        name_base_i,
  input  wire logic [23:0]        name_ext_i,
  input  wire logic               fat32_mode_i,
  output logic                    last_byte_o,
  output logic                    done_o,
  output dirl_pkg::dirl_entry_t   entry_o
);
  import dirl_pkg::*;

  localparam int unsigned SlotW = $clog2(ENTRIES_PER_SECTOR);

  logic [4:0]       off_q;
  logic [SlotW-1:0] slot_q;
  logic             mismatch_q;
  logic [7:0]       lead_q;
  logic [7:0]       attr_q;
  logic [15:0]      clus_hi_q;
  logic [15:0]      clus_lo_q;
  logic [23:0]      size_q;

  logic [7:0]       tgt [16];
  logic [7:0]       tgt_byte;
  logic             diff;
  logic [SlotW+3:0] slot_ext;
  logic [31:0]      cluster;
  entry_kind_e      kind;

  // Target name laid out by entry offset; offsets past the name read as zero.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      tgt[k] = 8'h00;
    end
    for (int k = 0; k < 8; k++) begin
      tgt[k] = name_base_i[8*k +: 8];
    end
    for (int k = 0; k < 3; k++) begin
      tgt[8+k] = name_ext_i[8*k +: 8];
    end
  end

  assign tgt_byte    = tgt[off_q[3:0]];
  assign diff        = (byte_i != tgt_byte);
  assign last_byte_o = (off_q == OFF_LAST);
  assign done_o      = byte_take_i && last_byte_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q      <= '0;
      slot_q     <= '0;
      mismatch_q <= 1'b0;
      lead_q     <= '0;
      attr_q     <= '0;
      clus_hi_q  <= '0;
      clus_lo_q  <= '0;
      size_q     <= '0;
    end else if (byte_take_i) begin
      off_q <= off_q + 5'd1;
      if (off_q < 5'(NameBytes)) begin
        if (off_q == OFF_LEAD) begin
          lead_q     <= byte_i;
          mismatch_q <= diff;
        end else begin
          mismatch_q <= mismatch_q | diff;
        end
      end
      case (off_q)
        OFF_ATTR:       attr_q          <= byte_i;
        OFF_CLUS_HI_LO: clus_hi_q[7:0]  <= byte_i;
        OFF_CLUS_HI_HI: clus_hi_q[15:8] <= byte_i;
        OFF_CLUS_LO_LO: clus_lo_q[7:0]  <= byte_i;
        OFF_CLUS_LO_HI: clus_lo_q[15:8] <= byte_i;
        OFF_SIZE_0:     size_q[7:0]     <= byte_i;
        OFF_SIZE_1:     size_q[15:8]    <= byte_i;
        OFF_SIZE_2:     size_q[23:16]   <= byte_i;
        default: ;
      endcase
      if (last_byte_o) begin
        if (slot_q == SlotW'(ENTRIES_PER_SECTOR - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + SlotW'(1);
        end
      end
    end
  end

  // The long-name test takes priority over the lead byte checks.
  always_comb begin
    if (attr_q[3:0] == ATTR_LFN_NIBBLE) begin
      kind = KIND_LONG_NAME;
    end else if (lead_q == LEAD_END_OF_LIST) begin
      kind = KIND_END_OF_LIST;
    end else if (lead_q == LEAD_DELETED) begin
      kind = KIND_DELETED;
    end else if (mismatch_q) begin
      kind = KIND_NO_MATCH;
    end else if (attr_q[AttrDirBit]) begin
      kind = KIND_DIR_MATCH;
    end else begin
      kind = KIND_FILE_MATCH;
    end
  end

  assign slot_ext = (SlotW + 4)'(slot_q);
  assign cluster  = {(fat32_mode_i ? clus_hi_q : 16'h0000), clus_lo_q};

  // The last size byte is the one arriving now, so it comes straight from the input.
  assign entry_o = '{
    kind:          kind,
    slot:          slot_ext[3:0],
    attributes:    attr_q,
    start_cluster: cluster,
    entry_size:    {byte_i, size_q}
  };

endmodule

`default_nettype wire

### rtl/directory_entry_lookup_core.sv
// Top level of the directory entry lookup block: configuration registers,
// the entry collector and the result register. Depends on dirl_pkg and dirl_collect.
`timescale 1ns / 1ps
`default_nettype none

// Directory sector bytes enter one per cycle on the entry_byte request channel.
// The 32nd byte of every entry yields one classification request on the output
// channel, loaded into a single result register and offered from the cycle after
// that byte is taken. A pending result only holds back the final byte of the next
// entry, so the input keeps streaming at one byte per cycle unless the output
// stays stalled for a whole entry. Configuration writes take effect at the next
// clock edge and should be made while no entry is half collected.
module directory_entry_lookup_core #(
  parameter int unsigned ENTRIES_PER_SECTOR = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  entry_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       entry_kind_o,
  output logic [3:0]       entry_slot_o,
  output logic [7:0]       entry_attributes_o,
  output logic [31:0]      start_cluster_o,
  output logic [31:0]      entry_size_o
);
  import dirl_pkg::*;

  logic [63:0] name_base_q;
  logic [23:0] name_ext_q;
  logic        fat32_q;
  logic        out_valid_q;
  dirl_entry_t out_q;
  logic        last_byte;
  logic        done;
  logic        take;
  dirl_entry_t entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_base_q <= '0;
      name_ext_q  <= '0;
      fat32_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NAME_BASE:  name_base_q <= cfg_data_i;
        REG_NAME_EXT:   name_ext_q  <= cfg_data_i[23:0];
        REG_FAT32_MODE: fat32_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !last_byte || !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  dirl_collect #(
    .ENTRIES_PER_SECTOR(ENTRIES_PER_SECTOR)
  ) u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_take_i (take),
    .byte_i      (entry_byte_i),
    .name_base_i (name_base_q),
    .name_ext_i  (name_ext_q),
    .fat32_mode_i(fat32_q),
    .last_byte_o (last_byte),
    .done_o      (done),
    .entry_o     (entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (done) begin
      out_q <= entry;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign entry_kind_o       = out_q.kind;
  assign entry_slot_o       = out_q.slot;
  assign entry_attributes_o = out_q.attributes;
  assign start_cluster_o    = out_q.start_cluster;
  assign entry_size_o       = out_q.entry_size;

endmodule

`default_nettype wire

### tb/sv/tb_directory_entry_lookup_core.sv
// Self-checking testbench for directory_entry_lookup_core: streams whole 32-byte directory
// entries, predicts each entry classification and checks every result request field by field.
// Depends on dirl_pkg and the directory_entry_lookup_core RTL.
`timescale 1ns / 1ps

module tb_directory_entry_lookup_core;
  import dirl_pkg::*;

  localparam int unsigned SlotsPerSector = 16;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RandomEntries  = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = REG_NAME_BASE;
  logic [63:0] cfg_data   = 64'd0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [7:0]  entry_byte = 8'd0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [2:0]  res_kind;
  logic [3:0]  res_slot;
  logic [7:0]  res_attr;
  logic [31:0] res_cluster;
  logic [31:0] res_size;

  // Bytes waiting to be sent and classifications waiting to come back.
  logic [7:0]  pending_bytes[$];
  dirl_entry_t expected_entries[$];

  // Predictor copy of the registers and of the entry collector.
  logic [63:0] tgt_base  = 64'd0;
  logic [23:0] tgt_ext   = 24'd0;
  logic        tgt_fat32 = 1'b0;
  logic [4:0]  byte_pos  = 5'd0;
  int unsigned slot_count = 0;
  logic        name_diff = 1'b0;
  logic [7:0]  lead_hold = 8'd0;
  logic [7:0]  attr_hold = 8'd0;
  logic [15:0] clus_hi   = 16'd0;
  logic [15:0] clus_lo   = 16'd0;
  logic [31:0] size_hold = 32'd0;

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  logic        no_idle   = 1'b0;
  int unsigned tx_wait   = 0;
  int unsigned rx_wait   = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  directory_entry_lookup_core #(
    .ENTRIES_PER_SECTOR(SlotsPerSector)
  ) uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .entry_byte_i      (entry_byte),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .entry_kind_o      (res_kind),
    .entry_slot_o      (res_slot),
    .entry_attributes_o(res_attr),
    .start_cluster_o   (res_cluster),
    .entry_size_o      (res_size)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Collects one sector byte and, on the last byte of an entry, queues its classification.
  task automatic take_sector_byte(input logic [7:0] b);
    int unsigned pos;
    logic [7:0]  want_byte;
    logic [31:0] cluster;
    dirl_entry_t res;
    pos = 32'(byte_pos);
    if (pos < NameBytes) begin
      want_byte = (pos < 8) ? tgt_base[8*pos +: 8] : tgt_ext[8*(pos-8) +: 8];
      if (byte_pos == OFF_LEAD) begin
        lead_hold = b;
        name_diff = (b != want_byte);
      end else begin
        name_diff = name_diff | (b != want_byte);
      end
    end else begin
      case (byte_pos)
        OFF_ATTR:       attr_hold = b;
        OFF_CLUS_HI_LO: clus_hi[7:0] = b;
        OFF_CLUS_HI_HI: clus_hi[15:8] = b;
        OFF_CLUS_LO_LO: clus_lo[7:0] = b;
        OFF_CLUS_LO_HI: clus_lo[15:8] = b;
        OFF_SIZE_0:     size_hold[7:0] = b;
        OFF_SIZE_1:     size_hold[15:8] = b;
        OFF_SIZE_2:     size_hold[23:16] = b;
        OFF_LAST:       size_hold[31:24] = b;
        default: ;
      endcase
    end
    if (byte_pos == OFF_LAST) begin
      if (attr_hold[3:0] == ATTR_LFN_NIBBLE) begin
        res.kind = KIND_LONG_NAME;
      end else if (lead_hold == LEAD_END_OF_LIST) begin
        res.kind = KIND_END_OF_LIST;
      end else if (lead_hold == LEAD_DELETED) begin
        res.kind = KIND_DELETED;
      end else if (name_diff) begin
        res.kind = KIND_NO_MATCH;
      end else begin
        res.kind = attr_hold[AttrDirBit] ? KIND_DIR_MATCH : KIND_FILE_MATCH;
      end
      cluster = {clus_hi, clus_lo};
      if (!tgt_fat32) cluster[31:16] = 16'd0;
      res.slot          = slot_count[3:0];
      res.attributes    = attr_hold;
      res.start_cluster = cluster;
      res.entry_size    = size_hold;
      expected_entries.push_back(res);
      slot_count = (slot_count + 1 >= SlotsPerSector) ? 0 : slot_count + 1;
    end
    byte_pos = byte_pos + 5'd1;
  endtask

  task automatic check_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Sampling at the rising edge: acceptances feed the predictor and the checker.
  always @(posedge clk) begin
    dirl_entry_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) take_sector_byte(entry_byte);
    if (rst_n && out_valid && out_ready) begin
      if (expected_entries.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual kind %0d slot %0d",
                 $time, res_kind, res_slot);
        error_count++;
      end else begin
        want = expected_entries.pop_front();
        check_field("entry_kind", 32'(want.kind), 32'(res_kind));
        check_field("entry_slot", 32'(want.slot), 32'(res_slot));
        check_field("entry_attributes", 32'(want.attributes), 32'(res_attr));
        check_field("start_cluster", want.start_cluster, res_cluster);
        check_field("entry_size", want.entry_size, res_size);
      end
    end
  end

  // Byte driver: a random gap before each request, with occasional stretches of none.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
      if (tx_wait != 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        entry_byte <= pending_bytes.pop_front();
        in_valid   <= 1'b1;
        tx_wait = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls for a random number of cycles after each accepted result.
  always @(negedge clk) begin
    if (out_taken) rx_wait = no_idle ? 0 : $urandom_range(0, 3);
    if (rx_wait != 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NAME_BASE:  tgt_base = val;
      REG_NAME_EXT:   tgt_ext = val[23:0];
      REG_FAT32_MODE: tgt_fat32 = val[0];
      default: ;
    endcase
  endtask

  task automatic set_target(input logic [63:0] base, input logic [23:0] ext, input logic fat32);
    write_reg(REG_NAME_BASE, base);
    write_reg(REG_NAME_EXT, {40'd0, ext});
    write_reg(REG_FAT32_MODE, {63'd0, fat32});
  endtask

  // Queues one whole entry; the reserved and time-stamp bytes are random.
  task automatic queue_entry(input logic [87:0] name, input logic [7:0] attr,
                             input logic [31:0] cluster, input logic [31:0] size);
    logic [7:0] b;
    for (int k = 0; k < 32; k++) begin
      if (k < NameBytes) b = name[8*k +: 8];
      else if (k == OFF_ATTR) b = attr;
      else if (k == OFF_CLUS_HI_LO) b = cluster[23:16];
      else if (k == OFF_CLUS_HI_HI) b = cluster[31:24];
      else if (k == OFF_CLUS_LO_LO) b = cluster[7:0];
      else if (k == OFF_CLUS_LO_HI) b = cluster[15:8];
      else if (k >= OFF_SIZE_0) b = size[8*(k-OFF_SIZE_0) +: 8];
      else b = 8'($urandom);
      pending_bytes.push_back(b);
    end
  endtask

  task automatic queue_fill(input logic [7:0] b);
    for (int k = 0; k < 32; k++) pending_bytes.push_back(b);
  endtask

  // Mostly well-formed entries built around the current target name, plus raw noise.
  task automatic queue_random_entry();
    int unsigned pick;
    int unsigned k;
    logic [87:0] nm;
    logic [7:0]  at;
    pick = $urandom_range(0, 9);
    nm = {tgt_ext, tgt_base};
    at = 8'($urandom);
    if (at[3:0] == ATTR_LFN_NIBBLE) at[0] = 1'b0;
    case (pick)
      4: begin
        k = $urandom_range(0, NameBytes - 1);
        nm[8*k +: 8] = nm[8*k +: 8] ^ 8'(1 << $urandom_range(0, 7));
      end
      5: nm[7:0] = LEAD_END_OF_LIST;
      6: nm[7:0] = LEAD_DELETED;
      7: at[3:0] = ATTR_LFN_NIBBLE;
      8, 9: begin
        nm = 88'({$urandom, $urandom, $urandom});
        at = 8'($urandom);
      end
      default: ;
    endcase
    queue_entry(nm, at, $urandom, $urandom);
  endtask

  task automatic queue_random_entries(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) queue_random_entry();
  endtask

  // Holds the sender back until every queued byte is taken and every result is back.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || expected_entries.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [63:0] random_base();
    logic [63:0] v;
    int unsigned len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < 8; k++) v[8*k +: 8] = (k < len) ? 8'($urandom_range(65, 90)) : 8'h20;
    return v;
  endfunction

  initial begin
    logic [87:0] readme;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: an all-zero entry reads as end of list.
    queue_fill(8'h00);
    queue_fill(8'hFF);
    queue_random_entries(RandomEntries);
    wait_idle();

    set_target(64'h2020_454D_4441_4552, 24'h545854, 1'b1);
    readme = {tgt_ext, tgt_base};
    queue_entry(readme, 8'h20, 32'h1234_5678, 32'h0000_1000);
    queue_entry(readme, 8'h10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_entry(readme, 8'h0F, 32'h0000_0002, 32'h0000_0000);
    queue_entry(readme, 8'h1F, 32'h0001_0000, 32'h0000_0001);
    queue_entry({readme[87:8], LEAD_DELETED}, 8'h20, 32'h0000_0003, 32'h0000_0040);
    // Classification carries on past an end-of-list entry.
    queue_entry({readme[87:8], LEAD_END_OF_LIST}, 8'h00, 32'h0000_0000, 32'h0000_0000);
    queue_entry(readme, 8'h00, 32'h0000_0000, 32'h0000_0000);
    queue_entry({readme[87:80] ^ 8'h01, readme[79:0]}, 8'h20, 32'h8000_0001, 32'h8000_0000);
    queue_random_entries(RandomEntries);
    wait_idle();

    set_target(64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF, 1'b0);
    queue_fill(8'hFF);
    queue_entry({88{1'b1}}, 8'h10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_entry({88{1'b1}}, 8'hE0, 32'hABCD_0000, 32'h0000_0000);
    queue_random_entries(RandomEntries);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 0) set_target({$urandom, $urandom}, 24'($urandom), 1'b1);
      else set_target(random_base(), 24'($urandom), 1'($urandom));
      queue_random_entries(RandomEntries);
      wait_idle();
    end

    if (error_count == 0 && expected_entries.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/dirl_pkg.sv
rtl/dirl_collect.sv
rtl/directory_entry_lookup_core.sv
tb/sv/tb_directory_entry_lookup_core.sv
